### rtl/core/tpdt_pkg.sv
package tpdt_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int KEY_W  = 16;
    localparam int VAL_W  = 16;
    localparam int THR_W  = 15;
    localparam int CIDX_W = 2;

    // item kinds
    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_DUMP   = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_NEW   = 3'd0;
    localparam logic [2:0] ST_ACC   = 3'd1;
    localparam logic [2:0] ST_FILT  = 3'd2;
    localparam logic [2:0] ST_FULL  = 3'd3;
    localparam logic [2:0] ST_DENT  = 3'd4;
    localparam logic [2:0] ST_EMPTY = 3'd5;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_MOOD_THR    = 2'd0;
    localparam logic [CIDX_W-1:0] REG_LOYALTY_THR = 2'd1;

    localparam logic [THR_W-1:0] MOOD_THR_RST    = 15'd819;
    localparam logic [THR_W-1:0] LOYALTY_THR_RST = 15'd614;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] mood;
        logic signed [VAL_W-1:0] loyalty;
    } t_entry;

    typedef struct packed {
        logic rotate;   // take the neighbor's entry
        logic acc_en;   // passing record: matching cell accumulates
        logic new_en;   // passing record, no match, room left: free cell loads
    } t_cell_ctl;

endpackage

### rtl/core/tpdt_rec_if.sv
interface tpdt_rec_if;
    import tpdt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic [KEY_W-1:0]        entry_key;
    logic signed [VAL_W-1:0] mood_delta;
    logic signed [VAL_W-1:0] loyalty_delta;
    logic [15:0]             tick_number;

    modport source (output valid, kind, entry_key, mood_delta, loyalty_delta, tick_number,
                    input ready);
    modport sink   (input valid, kind, entry_key, mood_delta, loyalty_delta, tick_number,
                    output ready);
endinterface

### rtl/core/tpdt_res_if.sv
interface tpdt_res_if;
    import tpdt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [2:0]              status;
    logic [KEY_W-1:0]        out_key;
    logic signed [VAL_W-1:0] mood_total;
    logic signed [VAL_W-1:0] loyalty_total;
    logic [15:0]             out_tick;
    logic                    saturated;
    logic                    last;

    modport source (output valid, status, out_key, mood_total, loyalty_total, out_tick,
                    saturated, last, input ready);
    modport sink   (input valid, status, out_key, mood_total, loyalty_total, out_tick,
                    saturated, last, output ready);
endinterface

### rtl/core/tpdt_cell.sv
module tpdt_cell
    import tpdt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                    i_clk,
    input  t_cell_ctl               i_ctl,
    input  logic [CW-1:0]           i_count,
    input  logic [KEY_W-1:0]        i_key,
    input  logic signed [VAL_W-1:0] i_md,
    input  logic signed [VAL_W-1:0] i_ld,
    input  t_entry                  i_nbr,
    output t_entry                  o_entry,
    output logic                    o_hit,
    output t_entry                  o_upd,
    output logic                    o_clip
);

    t_entry           r_ent;
    logic             used;
    logic             slot_free;
    logic [VAL_W:0]   m_sum;
    logic [VAL_W:0]   l_sum;
    logic             m_clip;
    logic             l_clip;

    assign used      = CW'(IDX) < i_count;
    assign slot_free = CW'(IDX) == i_count;
    assign o_hit     = i_ctl.acc_en && used && (r_ent.key == i_key);

    // 17-bit sums, clip when the top two bits disagree
    assign m_sum  = {r_ent.mood[VAL_W-1], r_ent.mood} + {i_md[VAL_W-1], i_md};
    assign l_sum  = {r_ent.loyalty[VAL_W-1], r_ent.loyalty} + {i_ld[VAL_W-1], i_ld};
    assign m_clip = m_sum[VAL_W] != m_sum[VAL_W-1];
    assign l_clip = l_sum[VAL_W] != l_sum[VAL_W-1];

    always_comb begin
        o_upd.key = r_ent.key;
        if (m_clip) begin
            o_upd.mood = m_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            o_upd.mood = m_sum[VAL_W-1:0];
        end
        if (l_clip) begin
            o_upd.loyalty = l_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            o_upd.loyalty = l_sum[VAL_W-1:0];
        end
    end

    assign o_clip  = m_clip || l_clip;
    assign o_entry = r_ent;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rotate) begin
            r_ent <= i_nbr;
        end else if (o_hit) begin
            r_ent <= o_upd;
        end else if (i_ctl.new_en && slot_free) begin
            r_ent.key     <= i_key;
            r_ent.mood    <= i_md;
            r_ent.loyalty <= i_ld;
        end
    end

endmodule

### rtl/core/thresholded_pair_delta_tracker_unit.sv
// record and clear words: the execute state registers the result once the output is free;
// the next word is taken only back in idle. dump word: the dump state registers the entries
// one per cycle from cell 0 as the cell row rotates, holding on an output stall while stored
// entries remain; the row then rotates past the used cells before the next word is taken
// synchronous active-low reset clears the fill count, the controller and the output valid,
// and restores default thresholds; the entry cells are not cleared
module thresholded_pair_delta_tracker_unit
    import tpdt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [THR_W-1:0]  i_cfg_data,
    tpdt_rec_if.sink          i_rec,
    tpdt_res_if.source        o_res
);

    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // controller states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] r_step, n_step;

    // thresholds
    logic [THR_W-1:0] r_mood_thr;
    logic [THR_W-1:0] r_loy_thr;

    // captured input word
    logic [1:0]              r_kind;
    logic [KEY_W-1:0]        r_key;
    logic signed [VAL_W-1:0] r_md;
    logic signed [VAL_W-1:0] r_ld;
    logic [15:0]             r_tick;

    // output register
    logic                    r_out_valid, n_out_valid;
    logic [2:0]              r_status, n_status;
    logic [KEY_W-1:0]        r_okey, n_okey;
    logic signed [VAL_W-1:0] r_mtot, n_mtot;
    logic signed [VAL_W-1:0] r_ltot, n_ltot;
    logic [15:0]             r_otick, n_otick;
    logic                    r_sat, n_sat;
    logic                    r_last, n_last;

    logic      in_acc;
    logic      out_free;
    logic      ld_out;
    t_cell_ctl ctl;

    // cell row signals
    t_entry                   ent   [TABLE_ENTRIES];
    t_entry                   upd   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] hit;
    logic [TABLE_ENTRIES-1:0] clip;
    t_entry                   hit_ent;
    logic                     hit_clip;
    logic                     any_hit;

    // filter: magnitudes on 17 bits so the most negative delta passes any threshold
    logic [VAL_W:0] m_mag;
    logic [VAL_W:0] l_mag;
    logic           pass;
    logic           full;

    assign m_mag = r_md[VAL_W-1] ? (VAL_W+1)'(-{r_md[VAL_W-1], r_md}) : {1'b0, r_md};
    assign l_mag = r_ld[VAL_W-1] ? (VAL_W+1)'(-{r_ld[VAL_W-1], r_ld}) : {1'b0, r_ld};
    assign pass  = (m_mag > {2'b00, r_mood_thr}) || (l_mag > {2'b00, r_loy_thr});
    assign full  = r_count == CW'(TABLE_ENTRIES);

    assign i_rec.ready = r_state == S_IDLE;
    assign in_acc      = i_rec.valid && i_rec.ready;
    assign out_free    = !r_out_valid || o_res.ready;

    // cell control: record updates fire only in the execute cycle that loads the result
    always_comb begin
        ctl.acc_en = (r_state == S_EXEC) && (r_kind == KIND_RECORD) && out_free && pass;
        ctl.new_en = ctl.acc_en && !any_hit && !full;
        ctl.rotate = (r_state == S_DUMP) && ((CW'(r_step) >= r_count) || out_free);
    end

    // the row: cell i takes cell i+1 on a rotate, the far end wraps to cell 0
    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        tpdt_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_count (r_count),
            .i_key   (r_key),
            .i_md    (r_md),
            .i_ld    (r_ld),
            .i_nbr   (ent[(g + 1) % TABLE_ENTRIES]),
            .o_entry (ent[g]),
            .o_hit   (hit[g]),
            .o_upd   (upd[g]),
            .o_clip  (clip[g])
        );
    end

    // keys are unique among used cells, so at most one hit: or-select its update
    always_comb begin
        hit_ent  = '0;
        hit_clip = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit[i]) begin
                hit_ent  = hit_ent | upd[i];
                hit_clip = hit_clip | clip[i];
            end
        end
    end

    assign any_hit = |hit;

    // sequencing and result formation
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_out_valid = r_out_valid && !o_res.ready;
        n_status    = r_status;
        n_okey      = r_okey;
        n_mtot      = r_mtot;
        n_ltot      = r_ltot;
        n_otick     = r_otick;
        n_sat       = r_sat;
        n_last      = r_last;
        ld_out      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_rec.kind inside {KIND_RECORD, KIND_DUMP, KIND_CLEAR}) begin
                        n_state = S_EXEC;
                    end
                    // unused kind: word is swallowed, nothing happens
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    n_okey  = r_key;
                    n_mtot  = '0;
                    n_ltot  = '0;
                    n_otick = '0;
                    n_sat   = 1'b0;
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                    if (r_kind == KIND_RECORD) begin
                        if (!pass) begin
                            n_status = ST_FILT;
                        end else if (any_hit) begin
                            n_status = ST_ACC;
                            n_mtot   = hit_ent.mood;
                            n_ltot   = hit_ent.loyalty;
                            n_sat    = hit_clip;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status = ST_NEW;
                            n_mtot   = r_md;
                            n_ltot   = r_ld;
                            n_count  = r_count + CW'(1);
                        end
                    end else if (r_kind == KIND_DUMP && r_count != '0) begin
                        // hand over to the rotating dump, no result here
                        ld_out  = 1'b0;
                        n_state = S_DUMP;
                        n_step  = '0;
                    end else begin
                        // clear, or dump of an empty table
                        n_status = ST_EMPTY;
                        n_okey   = '0;
                        n_otick  = r_tick;
                        if (r_kind == KIND_CLEAR) begin
                            n_count = '0;
                        end
                    end
                end
            end
            S_DUMP: begin
                if (ctl.rotate) begin
                    if (CW'(r_step) < r_count) begin
                        ld_out   = 1'b1;
                        n_status = ST_DENT;
                        n_okey   = ent[0].key;
                        n_mtot   = ent[0].mood;
                        n_ltot   = ent[0].loyalty;
                        n_otick  = r_tick;
                        n_sat    = 1'b0;
                        n_last   = (CW'(r_step) + CW'(1)) == r_count;
                    end
                    // keep rotating past the used cells so the row ends in order
                    if (r_step == SW'(TABLE_ENTRIES - 1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_step = r_step + SW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (ld_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_mood_thr  <= MOOD_THR_RST;
            r_loy_thr   <= LOYALTY_THR_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_MOOD_THR) begin
                    r_mood_thr <= i_cfg_data;
                end else if (i_cfg_idx == REG_LOYALTY_THR) begin
                    r_loy_thr <= i_cfg_data;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_rec.kind;
            r_key  <= i_rec.entry_key;
            r_md   <= i_rec.mood_delta;
            r_ld   <= i_rec.loyalty_delta;
            r_tick <= i_rec.tick_number;
        end
        r_status <= n_status;
        r_okey   <= n_okey;
        r_mtot   <= n_mtot;
        r_ltot   <= n_ltot;
        r_otick  <= n_otick;
        r_sat    <= n_sat;
        r_last   <= n_last;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_status;
    assign o_res.out_key       = r_okey;
    assign o_res.mood_total    = r_mtot;
    assign o_res.loyalty_total = r_ltot;
    assign o_res.out_tick      = r_otick;
    assign o_res.saturated     = r_sat;
    assign o_res.last          = r_last;

    // fill count never passes the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    // stored keys stay unique, so a record matches at most one cell
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(hit))
        else $error("record matched more than one cell");

    // a dump is only walked with something in the table
    a_dump_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_count != '0))
        else $error("dump walk on empty table");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ld_out |-> (!r_out_valid || o_res.ready))
        else $error("result register overwritten");

endmodule
